FILE: src/ppt_pkg.sv
// Shared constants and types for the perspective point transform.
// Holds fixed-point formats and configuration register indexes; no dependencies.
package ppt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 32;

  localparam int IN_BITS   = 3 * COORD_WIDTH;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 * COORD_WIDTH + 2;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_H00_H01  = 3'd0,
    CFG_H02_H10  = 3'd1,
    CFG_H11_H12  = 3'd2,
    CFG_H20_H21  = 3'd3,
    CFG_H22      = 3'd4,
    CFG_MAP_INV  = 3'd5,
    CFG_SPARE6   = 3'd6,
    CFG_SPARE7   = 3'd7
  } cfg_idx_e;

endpackage

FILE: src/perspective_point_transform_top.sv
// Homography point transform: 3x3 matrix times (x, y, z), then divide by the third row.
// Uses ppt_pkg for formats and register indexes.
//
// One item per cycle is accepted whenever the output register is free or being taken.
// The pipeline has one stage of nine multipliers, one of row sums, one of magnitude
// setup, one of overflow check, one stage per quotient bit of the two restoring
// dividers, and the output register.
// A stall on the master side holds the whole pipeline.
module perspective_point_transform_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ppt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // in_x, in_y, in_z
  input  logic [ppt_pkg::IN_TDATA-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_w_one, div_zero, zero pad
  output logic [ppt_pkg::OUT_TDATA-1:0]     m_axis_tdata
);
  import ppt_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int PW  = COEF_WIDTH + CW;
  localparam int SW  = PW + 2;
  localparam int XW  = (CW > FRAC_BITS) ? CW : FRAC_BITS;
  localparam int RW  = SW + XW + 1;
  localparam int NST = CW + 5;

  typedef struct packed {
    logic [RW-1:0] rem_x;
    logic [RW-1:0] rem_y;
    logic [CW-1:0] q_x;
    logic [CW-1:0] q_y;
    logic [RW-1:0] dv;
    logic          neg_x;
    logic          neg_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          dz;
    logic          inv;
  } dv_t;

  logic [CFG_DATA_W-1:0] coef_q [4];
  logic [COEF_WIDTH-1:0] h22_q;
  logic                  inv_q;
  logic signed [COEF_WIDTH-1:0] h [9];

  logic [NST-1:0] vld_q;
  logic           en;

  logic signed [PW-1:0] prod_q [9];
  logic                 inv1_q;
  logic signed [SW-1:0] r_q [3];
  logic                 inv2_q;
  logic [RW-1:0]        nx_q, ny_q, d_q;
  logic                 negx_q, negy_q, zx_q, zy_q, dz3_q, inv3_q;
  dv_t                  dv_q [CW+1];
  dv_t                  dv_d [CW];

  logic [CW-1:0] ox_q, oy_q;
  logic          ow_q, odz_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {{(OUT_TDATA-OUT_BITS){1'b0}}, odz_q, ow_q, oy_q, ox_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CFG_DATA_W'(65536);
      coef_q[1] <= '0;
      coef_q[2] <= CFG_DATA_W'(65536);
      coef_q[3] <= '0;
      h22_q     <= COEF_WIDTH'(65536);
      inv_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_H00_H01: coef_q[0] <= cfg_data_i;
        CFG_H02_H10: coef_q[1] <= cfg_data_i;
        CFG_H11_H12: coef_q[2] <= cfg_data_i;
        CFG_H20_H21: coef_q[3] <= cfg_data_i;
        CFG_H22:     h22_q     <= cfg_data_i[COEF_WIDTH-1:0];
        CFG_MAP_INV: inv_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h[2*i]   = $signed(coef_q[i][COEF_WIDTH-1:0]);
      h[2*i+1] = $signed(coef_q[i][2*COEF_WIDTH-1:COEF_WIDTH]);
    end
    h[8] = $signed(h22_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[3*i]   <= PW'(h[3*i]   * $signed(s_axis_tdata[CW-1:0]));
        prod_q[3*i+1] <= PW'(h[3*i+1] * $signed(s_axis_tdata[2*CW-1:CW]));
        prod_q[3*i+2] <= PW'(h[3*i+2] * $signed(s_axis_tdata[3*CW-1:2*CW]));
      end
      inv1_q <= inv_q;
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_q[i] <= SW'(prod_q[3*i]) + SW'(prod_q[3*i+1]) + SW'(prod_q[3*i+2]);
      end
      inv2_q <= inv1_q;
    end
  end

  // stage 3: magnitudes and signs
  logic [SW-1:0] mx, my, md;
  always_comb begin
    mx = r_q[0][SW-1] ? SW'(-r_q[0]) : SW'(r_q[0]);
    my = r_q[1][SW-1] ? SW'(-r_q[1]) : SW'(r_q[1]);
    md = r_q[2][SW-1] ? SW'(-r_q[2]) : SW'(r_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q   <= RW'(mx) << FRAC_BITS;
      ny_q   <= RW'(my) << FRAC_BITS;
      d_q    <= RW'(md);
      negx_q <= r_q[0][SW-1] ^ r_q[2][SW-1];
      negy_q <= r_q[1][SW-1] ^ r_q[2][SW-1];
      zx_q   <= (r_q[0] == '0);
      zy_q   <= (r_q[1] == '0);
      dz3_q  <= (r_q[2] == '0);
      inv3_q <= inv2_q;
    end
  end

  // stage 4: quotient overflow past CW bits; zero divisor forces limit unless the numerator is zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].rem_x <= nx_q;
      dv_q[0].rem_y <= ny_q;
      dv_q[0].q_x   <= '0;
      dv_q[0].q_y   <= '0;
      dv_q[0].dv    <= d_q;
      dv_q[0].neg_x <= negx_q;
      dv_q[0].neg_y <= negy_q;
      dv_q[0].ovf_x <= dz3_q ? !zx_q : (nx_q >= (d_q << CW));
      dv_q[0].ovf_y <= dz3_q ? !zy_q : (ny_q >= (d_q << CW));
      dv_q[0].dz    <= dz3_q;
      dv_q[0].inv   <= inv3_q;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int B = CW - 1 - k;
    logic [RW-1:0] sh;
    always_comb begin
      sh = dv_q[k].dv << B;
      dv_d[k] = dv_q[k];
      if (dv_q[k].rem_x >= sh) begin
        dv_d[k].rem_x  = dv_q[k].rem_x - sh;
        dv_d[k].q_x[B] = 1'b1;
      end
      if (dv_q[k].rem_y >= sh) begin
        dv_d[k].rem_y  = dv_q[k].rem_y - sh;
        dv_d[k].q_y[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= dv_d[k];
      end
    end
  end

  // output: saturate, sign; zero divisor without overflow means zero numerator; MAP_INV zeroes all
  localparam logic [CW-1:0] LIM_P = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LIM_N = {1'b1, {(CW-1){1'b0}}};
  dv_t           fin;
  logic [CW-1:0] lx, ly, mgx, mgy;
  always_comb begin
    fin = dv_q[CW];
    lx  = fin.neg_x ? LIM_N : LIM_P;
    ly  = fin.neg_y ? LIM_N : LIM_P;
    mgx = fin.ovf_x ? lx : (fin.dz ? '0 : ((fin.q_x > lx) ? lx : fin.q_x));
    mgy = fin.ovf_y ? ly : (fin.dz ? '0 : ((fin.q_y > ly) ? ly : fin.q_y));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q  <= fin.inv ? '0 : (fin.neg_x ? CW'(-mgx) : mgx);
      oy_q  <= fin.inv ? '0 : (fin.neg_y ? CW'(-mgy) : mgy);
      ow_q  <= !fin.inv;
      odz_q <= !fin.inv && fin.dz;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && odz_q |-> ow_q)
    else $error("div_zero without valid mapping");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !ow_q |-> ox_q == '0 && oy_q == '0 && !odz_q)
    else $error("invalid mapping gave nonzero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("pipeline enable mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
